// ===== rtl/sha256_pkg.sv =====
// sha256_pkg: payload structs, round constants, initial values and helpers
// used by the front (packer), the back (compression core) and the top level
`default_nettype none
package sha256_pkg;

    typedef struct packed {
        logic [7:0] data_byte;
        logic       byte_present;
        logic       end_of_message;
    } sha_in_t;

    typedef struct packed {
        logic [31:0] digest_word;
        logic [2:0]  word_index;
        logic        last_word;
    } sha_out_t;

    // one block handed from the front to the back
    typedef struct packed {
        logic [511:0] data;
        logic         final_blk;
    } sha_blk_t;

    typedef enum logic [1:0] {
        CORE_IDLE,
        CORE_ROUND,
        CORE_UPDATE,
        CORE_EMIT
    } core_state_t;

    typedef enum logic [1:0] {
        PACK_ABSORB,
        PACK_PAD,
        PACK_LEN
    } pack_state_t;

    localparam int unsigned SHA224_WORDS = 7;
    localparam int unsigned SHA256_WORDS = 8;

    function automatic logic [31:0] iv_word(input logic mode224, input logic [2:0] idx);
        logic [31:0] w;
        if (mode224)
        begin
            unique case (idx)
                3'd0: w = 32'hC1059ED8;
                3'd1: w = 32'h367CD507;
                3'd2: w = 32'h3070DD17;
                3'd3: w = 32'hF70E5939;
                3'd4: w = 32'hFFC00B31;
                3'd5: w = 32'h68581511;
                3'd6: w = 32'h64F98FA7;
                default: w = 32'hBEFA4FA4;
            endcase
        end
        else
        begin
            unique case (idx)
                3'd0: w = 32'h6A09E667;
                3'd1: w = 32'hBB67AE85;
                3'd2: w = 32'h3C6EF372;
                3'd3: w = 32'hA54FF53A;
                3'd4: w = 32'h510E527F;
                3'd5: w = 32'h9B05688C;
                3'd6: w = 32'h1F83D9AB;
                default: w = 32'h5BE0CD19;
            endcase
        end
        return w;
    endfunction

    function automatic logic [31:0] round_k(input logic [5:0] t);
        logic [31:0] k;
        unique case (t)
            6'd0: k = 32'h428A2F98;  6'd1: k = 32'h71374491;  6'd2: k = 32'hB5C0FBCF;
            6'd3: k = 32'hE9B5DBA5;  6'd4: k = 32'h3956C25B;  6'd5: k = 32'h59F111F1;
            6'd6: k = 32'h923F82A4;  6'd7: k = 32'hAB1C5ED5;  6'd8: k = 32'hD807AA98;
            6'd9: k = 32'h12835B01;  6'd10: k = 32'h243185BE; 6'd11: k = 32'h550C7DC3;
            6'd12: k = 32'h72BE5D74; 6'd13: k = 32'h80DEB1FE; 6'd14: k = 32'h9BDC06A7;
            6'd15: k = 32'hC19BF174; 6'd16: k = 32'hE49B69C1; 6'd17: k = 32'hEFBE4786;
            6'd18: k = 32'h0FC19DC6; 6'd19: k = 32'h240CA1CC; 6'd20: k = 32'h2DE92C6F;
            6'd21: k = 32'h4A7484AA; 6'd22: k = 32'h5CB0A9DC; 6'd23: k = 32'h76F988DA;
            6'd24: k = 32'h983E5152; 6'd25: k = 32'hA831C66D; 6'd26: k = 32'hB00327C8;
            6'd27: k = 32'hBF597FC7; 6'd28: k = 32'hC6E00BF3; 6'd29: k = 32'hD5A79147;
            6'd30: k = 32'h06CA6351; 6'd31: k = 32'h14292967; 6'd32: k = 32'h27B70A85;
            6'd33: k = 32'h2E1B2138; 6'd34: k = 32'h4D2C6DFC; 6'd35: k = 32'h53380D13;
            6'd36: k = 32'h650A7354; 6'd37: k = 32'h766A0ABB; 6'd38: k = 32'h81C2C92E;
            6'd39: k = 32'h92722C85; 6'd40: k = 32'hA2BFE8A1; 6'd41: k = 32'hA81A664B;
            6'd42: k = 32'hC24B8B70; 6'd43: k = 32'hC76C51A3; 6'd44: k = 32'hD192E819;
            6'd45: k = 32'hD6990624; 6'd46: k = 32'hF40E3585; 6'd47: k = 32'h106AA070;
            6'd48: k = 32'h19A4C116; 6'd49: k = 32'h1E376C08; 6'd50: k = 32'h2748774C;
            6'd51: k = 32'h34B0BCB5; 6'd52: k = 32'h391C0CB3; 6'd53: k = 32'h4ED8AA4A;
            6'd54: k = 32'h5B9CCA4F; 6'd55: k = 32'h682E6FF3; 6'd56: k = 32'h748F82EE;
            6'd57: k = 32'h78A5636F; 6'd58: k = 32'h84C87814; 6'd59: k = 32'h8CC70208;
            6'd60: k = 32'h90BEFFFA; 6'd61: k = 32'hA4506CEB; 6'd62: k = 32'hBEF9A3F7;
            default: k = 32'hC67178F2;
        endcase
        return k;
    endfunction

    function automatic logic [31:0] rotr(input logic [31:0] x, input int unsigned n);
        return (x >> n) | (x << (32 - n));
    endfunction

endpackage
`default_nettype wire

// ===== rtl/sha256_hash_engine.sv =====
`default_nettype none
// sha256_hash_engine: top level, byte packer, block queue, compression core
// depends on sha256_pkg, sha256_packer, sha256_blk_queue, sha256_core
//
//   channel   handshake        payload
//   input     push / full      in_item  (sha_in_t)
//   result    pop / empty      out_item (sha_out_t)
//   config    cfg_we           cfg_data (sha224_mode)
//
// bytes go in one a cycle while full is low; full rises after every 64th
// byte while the block goes to the two-block queue, and after an end request
// while the padding block, and a second one when the padding spills, is made
// and handed on; each block passes through the core as one load, 64 rounds
// and one chaining update; the digest then leaves one word per pop, 7 or 8 of them
// reset and mode writes load the initial values, empty the queue and drop the
// message in progress
module sha256_hash_engine
    import sha256_pkg::*;
(
    input  wire logic     clk,
    input  wire logic     rst_n,
    input  wire logic     push,
    output logic          full,
    input  wire sha_in_t  in_item,
    input  wire logic     pop,
    output logic          empty,
    output sha_out_t      out_item,
    input  wire logic     cfg_we,
    input  wire logic     cfg_data
);

    logic     mode_reg;
    logic     in_ready, pk_valid, pk_ready, q_valid, q_ready, out_valid;
    sha_blk_t pk_blk, q_blk;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg <= 1'b0;
        end
        else if (cfg_we)
        begin
            mode_reg <= cfg_data;
        end
    end

    assign full  = !in_ready;
    assign empty = !out_valid;

    sha256_packer u_packer (
        .clk       (clk),
        .rst_n     (rst_n),
        .flush     (cfg_we),
        .in_item   (in_item),
        .in_valid  (push),
        .in_ready  (in_ready),
        .blk       (pk_blk),
        .blk_valid (pk_valid),
        .blk_ready (pk_ready)
    );

    sha256_blk_queue u_queue (
        .clk      (clk),
        .rst_n    (rst_n),
        .flush    (cfg_we),
        .wr_blk   (pk_blk),
        .wr_valid (pk_valid),
        .wr_ready (pk_ready),
        .rd_blk   (q_blk),
        .rd_valid (q_valid),
        .rd_ready (q_ready)
    );

    sha256_core u_core (
        .clk       (clk),
        .rst_n     (rst_n),
        .flush     (cfg_we),
        .mode224   (cfg_we ? cfg_data : mode_reg),
        .blk       (q_blk),
        .blk_valid (q_valid),
        .blk_ready (q_ready),
        .out_item  (out_item),
        .out_valid (out_valid),
        .out_ready (pop)
    );

endmodule
`default_nettype wire

// ===== rtl/sha256_packer.sv =====
// sha256_packer: front part, collects bytes into 64-byte blocks and pads
// depends on sha256_pkg
`default_nettype none
module sha256_packer
    import sha256_pkg::*;
(
    input  wire logic     clk,
    input  wire logic     rst_n,
    input  wire logic     flush,
    input  wire sha_in_t  in_item,
    input  wire logic     in_valid,
    output logic          in_ready,
    output sha_blk_t      blk,
    output logic          blk_valid,
    input  wire logic     blk_ready
);

    pack_state_t  state_reg, state_next;
    logic [511:0] buf_reg, buf_next;
    logic [60:0]  count_reg, count_next;
    logic         hold_reg, hold_next;
    logic         fin_reg, fin_next;
    logic [5:0]   pos;
    logic [63:0]  bits;

    assign pos       = count_reg[5:0];
    assign bits      = {count_reg, 3'b000};
    assign blk.data  = buf_reg;
    assign blk.final_blk = fin_reg;
    assign blk_valid = hold_reg;
    assign in_ready  = (state_reg == PACK_ABSORB) && !hold_reg;

    always_comb
    begin
        state_next = state_reg;
        buf_next   = buf_reg;
        count_next = count_reg;
        hold_next  = hold_reg;
        fin_next   = fin_reg;
        if (hold_reg && blk_ready)
        begin
            hold_next = 1'b0;
        end
        if (!hold_reg)
        begin
            unique case (state_reg)
                PACK_ABSORB:
                begin
                    if (in_valid)
                    begin
                        if (in_item.byte_present)
                        begin
                            buf_next[511 - 8*pos -: 8] = in_item.data_byte;
                            count_next = count_reg + 61'd1;
                            if (pos == 6'd63)
                            begin
                                hold_next = 1'b1;
                                fin_next  = 1'b0;
                            end
                        end
                        if (in_item.end_of_message)
                        begin
                            state_next = PACK_PAD;
                        end
                    end
                end
                PACK_PAD:
                begin
                    // 0x80 then zeros; spill to a second block past byte 55
                    buf_next[511 - 8*pos -: 8] = 8'h80;
                    for (int i = 0; i < 64; i++)
                    begin
                        if (i > int'(pos))
                        begin
                            buf_next[511 - 8*i -: 8] = 8'h00;
                        end
                    end
                    if (pos > 6'd55)
                    begin
                        hold_next  = 1'b1;
                        fin_next   = 1'b0;
                        state_next = PACK_LEN;
                    end
                    else
                    begin
                        buf_next[63:0] = bits;
                        hold_next  = 1'b1;
                        fin_next   = 1'b1;
                        count_next = '0;
                        state_next = PACK_ABSORB;
                    end
                end
                PACK_LEN:
                begin
                    buf_next   = {448'd0, bits};
                    hold_next  = 1'b1;
                    fin_next   = 1'b1;
                    count_next = '0;
                    state_next = PACK_ABSORB;
                end
                default:
                begin
                    state_next = PACK_ABSORB;
                end
            endcase
        end
        if (flush)
        begin
            count_next = '0;
            hold_next  = 1'b0;
            state_next = PACK_ABSORB;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= PACK_ABSORB;
            count_reg <= '0;
            hold_reg  <= 1'b0;
            fin_reg   <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            count_reg <= count_next;
            hold_reg  <= hold_next;
            fin_reg   <= fin_next;
        end
    end

    always_ff @(posedge clk)
    begin
        buf_reg <= buf_next;
    end

endmodule
`default_nettype wire

// ===== rtl/sha256_blk_queue.sv =====
// sha256_blk_queue: two-entry block queue between packer and core
// depends on sha256_pkg
`default_nettype none
module sha256_blk_queue
    import sha256_pkg::*;
(
    input  wire logic     clk,
    input  wire logic     rst_n,
    input  wire logic     flush,
    input  wire sha_blk_t wr_blk,
    input  wire logic     wr_valid,
    output logic          wr_ready,
    output sha_blk_t      rd_blk,
    output logic          rd_valid,
    input  wire logic     rd_ready
);

    sha_blk_t    mem_reg [2];
    logic        wp_reg, rp_reg;
    logic [1:0]  cnt_reg;
    logic        do_wr, do_rd;

    assign wr_ready = cnt_reg != 2'd2;
    assign rd_valid = cnt_reg != 2'd0;
    assign rd_blk   = mem_reg[rp_reg];
    assign do_wr    = wr_valid && wr_ready;
    assign do_rd    = rd_valid && rd_ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wp_reg  <= 1'b0;
            rp_reg  <= 1'b0;
            cnt_reg <= 2'd0;
        end
        else if (flush)
        begin
            wp_reg  <= 1'b0;
            rp_reg  <= 1'b0;
            cnt_reg <= 2'd0;
        end
        else
        begin
            if (do_wr)
            begin
                wp_reg <= ~wp_reg;
            end
            if (do_rd)
            begin
                rp_reg <= ~rp_reg;
            end
            cnt_reg <= cnt_reg + {1'b0, do_wr} - {1'b0, do_rd};
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_wr)
        begin
            mem_reg[wp_reg] <= wr_blk;
        end
    end

endmodule
`default_nettype wire

// ===== rtl/sha256_core.sv =====
// sha256_core: back part, 64-round compression at one round a cycle and
// digest output register; depends on sha256_pkg
`default_nettype none
module sha256_core
    import sha256_pkg::*;
(
    input  wire logic     clk,
    input  wire logic     rst_n,
    input  wire logic     flush,
    input  wire logic     mode224,
    input  wire sha_blk_t blk,
    input  wire logic     blk_valid,
    output logic          blk_ready,
    output sha_out_t      out_item,
    output logic          out_valid,
    input  wire logic     out_ready
);

    core_state_t  state_reg, state_next;
    logic [31:0]  h_reg [8];
    logic [31:0]  v_reg [8];
    logic [31:0]  w_reg [16];
    logic [5:0]   t_reg;
    logic         fin_reg;
    logic [2:0]  widx_reg;
    logic [31:0] w_cur, w_new, s0, s1, t1, t2, e, a;
    logic        last;

    assign e = v_reg[4];
    assign a = v_reg[0];
    assign s0 = rotr(w_reg[1], 7) ^ rotr(w_reg[1], 18) ^ (w_reg[1] >> 3);
    assign s1 = rotr(w_reg[14], 17) ^ rotr(w_reg[14], 19) ^ (w_reg[14] >> 10);
    assign w_new = s1 + w_reg[9] + s0 + w_reg[0];
    // w_reg is a sliding window: w_reg[0] is the word of the current round in rounds 0 to 15, and W[t-16] after that
    assign w_cur = (t_reg < 6'd16) ? w_reg[0] : w_new;
    assign t1 = v_reg[7] + (rotr(e, 6) ^ rotr(e, 11) ^ rotr(e, 25))
              + (v_reg[6] ^ (e & (v_reg[5] ^ v_reg[6]))) + round_k(t_reg) + w_cur;
    assign t2 = (rotr(a, 2) ^ rotr(a, 13) ^ rotr(a, 22))
              + ((a & v_reg[1]) | (v_reg[2] & (a | v_reg[1])));
    assign last = mode224 ? (widx_reg == 3'(SHA224_WORDS - 1))
                          : (widx_reg == 3'(SHA256_WORDS - 1));

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            CORE_IDLE:   if (blk_valid) state_next = CORE_ROUND;
            CORE_ROUND:  if (t_reg == 6'd63) state_next = CORE_UPDATE;
            CORE_UPDATE: state_next = fin_reg ? CORE_EMIT : CORE_IDLE;
            CORE_EMIT:   if (out_ready && last) state_next = CORE_IDLE;
            default:     state_next = CORE_IDLE;
        endcase
        if (flush)
        begin
            state_next = CORE_IDLE;
        end
    end

    always_comb
    begin
        blk_ready = (state_reg == CORE_IDLE);
        out_valid = (state_reg == CORE_EMIT);
        out_item.digest_word = h_reg[widx_reg];
        out_item.word_index  = widx_reg;
        out_item.last_word   = last;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= CORE_IDLE;
            t_reg     <= '0;
            widx_reg  <= '0;
            fin_reg   <= 1'b0;
            for (int i = 0; i < 8; i++)
            begin
                h_reg[i] <= iv_word(1'b0, 3'(i));
            end
        end
        else
        begin
            state_reg <= state_next;
            if (flush)
            begin
                t_reg    <= '0;
                widx_reg <= '0;
                for (int i = 0; i < 8; i++)
                begin
                    h_reg[i] <= iv_word(mode224, 3'(i));
                end
            end
            else
            begin
                unique case (state_reg)
                    CORE_IDLE:
                    begin
                        t_reg   <= '0;
                        fin_reg <= blk.final_blk;
                    end
                    CORE_ROUND:
                    begin
                        t_reg <= t_reg + 6'd1;
                    end
                    CORE_UPDATE:
                    begin
                        widx_reg <= '0;
                        for (int i = 0; i < 8; i++)
                        begin
                            h_reg[i] <= h_reg[i] + v_reg[i];
                        end
                    end
                    CORE_EMIT:
                    begin
                        if (out_ready)
                        begin
                            widx_reg <= widx_reg + 3'd1;
                            if (last)
                            begin
                                widx_reg <= '0;
                                for (int i = 0; i < 8; i++)
                                begin
                                    h_reg[i] <= iv_word(mode224, 3'(i));
                                end
                            end
                        end
                    end
                    default:
                    begin
                        t_reg <= '0;
                    end
                endcase
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (state_reg == CORE_IDLE)
        begin
            for (int i = 0; i < 16; i++)
            begin
                w_reg[i] <= blk.data[511 - 32*i -: 32];
            end
            for (int i = 0; i < 8; i++)
            begin
                v_reg[i] <= h_reg[i];
            end
        end
        else if (state_reg == CORE_ROUND)
        begin
            for (int i = 0; i < 15; i++)
            begin
                w_reg[i] <= w_reg[i + 1];
            end
            w_reg[15] <= w_cur;
            v_reg[7] <= v_reg[6];
            v_reg[6] <= v_reg[5];
            v_reg[5] <= v_reg[4];
            v_reg[4] <= v_reg[3] + t1;
            v_reg[3] <= v_reg[2];
            v_reg[2] <= v_reg[1];
            v_reg[1] <= v_reg[0];
            v_reg[0] <= t1 + t2;
        end
    end

endmodule
`default_nettype wire
